### design/qpe_pkg.sv
// ----------------------------------------------------------------------------
// Quoted-printable encoder package
// Shared types, character constants and character lookup functions.
// ----------------------------------------------------------------------------
package qpe_pkg;

	localparam int unsigned COL_W = 7;

	typedef logic [COL_W-1:0] col_t;

	typedef enum logic [1:0] {
		CLS_OTHER   = 2'd0,
		CLS_BLANK   = 2'd1,
		CLS_NEWLINE = 2'd2
	} cls_t;

	typedef enum logic [2:0] {
		BODY_NONE     = 3'd0,
		BODY_LIT      = 3'd1,
		BODY_ESC      = 3'd2,
		BODY_LF       = 3'd3,
		BODY_BLANK_LF = 3'd4,
		BODY_CLOSE    = 3'd5
	} body_t;

	typedef struct packed {
		logic [2:0] pfx_len;
		logic       pfx_esc;
		logic       brk1;
		body_t      body;
		logic [7:0] body_byte;
		logic       brk2;
	} cmd_t;

	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_EQ  = 8'h3D;
	localparam logic [7:0] CH_F   = 8'h46;
	localparam logic [7:0] CH_DEL = 8'h7F;
	localparam logic [7:0] CH_CTL_END = 8'h20;

	localparam col_t LIMIT_RESET = 7'd72;

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		hex_char = (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h37 + {4'h0, n});
	endfunction

	function automatic logic [7:0] from_char(input logic [2:0] i);
		case (i)
			3'd0: from_char = 8'h46;
			3'd1: from_char = 8'h72;
			3'd2: from_char = 8'h6F;
			3'd3: from_char = 8'h6D;
			default: from_char = CH_SP;
		endcase
	endfunction

	function automatic logic [7:0] esc_from_char(input logic [2:0] i);
		case (i)
			3'd0: esc_from_char = CH_EQ;
			3'd1: esc_from_char = 8'h34;
			3'd2: esc_from_char = 8'h36;
			3'd3: esc_from_char = 8'h72;
			3'd4: esc_from_char = 8'h6F;
			default: esc_from_char = 8'h6D;
		endcase
	endfunction

	function automatic logic [7:0] break_char(input logic [1:0] j);
		case (j)
			2'd0: break_char = CH_EQ;
			2'd1: break_char = CH_CR;
			default: break_char = CH_LF;
		endcase
	endfunction

	function automatic logic [1:0] body_len(input body_t k);
		case (k)
			BODY_NONE: body_len = 2'd0;
			BODY_LIT, BODY_LF: body_len = 2'd1;
			default: body_len = 2'd3;
		endcase
	endfunction

	function automatic logic [7:0] body_char(input body_t k, input logic [7:0] b,
			input logic [1:0] j);
		case (k)
			BODY_LIT: body_char = b;
			BODY_LF: body_char = CH_LF;
			BODY_ESC: begin
				case (j)
					2'd0: body_char = CH_EQ;
					2'd1: body_char = hex_char(b[7:4]);
					default: body_char = hex_char(b[3:0]);
				endcase
			end
			BODY_BLANK_LF: body_char = (j == 2'd0) ? CH_EQ : CH_LF;
			BODY_CLOSE: body_char = break_char(j);
			default: body_char = b;
		endcase
	endfunction

endpackage

### design/qpe_in_if.sv
// ----------------------------------------------------------------------------
// Quoted-printable encoder input channel
// Carries one raw message byte or an end mark per request.
// ----------------------------------------------------------------------------
interface qpe_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_message;

	modport source(output valid, output data_byte, output end_of_message, input ready);
	modport sink(input valid, input data_byte, input end_of_message, output ready);
endinterface

### design/qpe_out_if.sv
// ----------------------------------------------------------------------------
// Quoted-printable encoder output channel
// Carries one encoded character per request.
// ----------------------------------------------------------------------------
interface qpe_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;

	modport source(output valid, output out_byte, output last, input ready);
	modport sink(input valid, input out_byte, input last, output ready);
endinterface

### design/qpe_front.sv
// ----------------------------------------------------------------------------
// Quoted-printable encoder front end
// Accepts input requests, tracks line state and classifies each byte into a
// compact output command for the back end.
// ----------------------------------------------------------------------------
module qpe_front (
	input  logic          clk,
	input  logic          arst_n,
	qpe_in_if.sink        data_ch,
	input  logic          cfg_wr_en,
	input  logic [6:0]    cfg_wr_data,
	input  logic          q_full,
	output logic          q_push,
	output qpe_pkg::cmd_t q_cmd
);

	qpe_pkg::col_t limit_q;
	qpe_pkg::col_t col_q;
	qpe_pkg::cls_t cls_q;
	logic [2:0]    prog_q;

	qpe_pkg::col_t col_nx;
	qpe_pkg::cls_t cls_nx;
	logic [2:0]    prog_nx;
	qpe_pkg::cmd_t cmd;
	logic          accept;

	assign data_ch.ready = !q_full;
	assign accept = data_ch.valid && data_ch.ready;
	assign q_cmd = cmd;
	assign q_push = accept && ((cmd.pfx_len != 3'd0) || (cmd.body != qpe_pkg::BODY_NONE));

	always_comb begin
		logic [7:0]    c;
		logic [2:0]    p;
		logic          in_prog;
		logic          do_enc;
		logic          esc;
		logic [7:0]    sum;
		qpe_pkg::col_t col1;
		qpe_pkg::cls_t cls1;
		c = data_ch.data_byte;
		p = prog_q;
		in_prog = (p >= 3'd1) && (p <= 3'd4);
		do_enc = 1'b0;
		esc = 1'b0;
		sum = 8'd0;
		col1 = col_q;
		cls1 = cls_q;
		cmd = '0;
		cmd.body = qpe_pkg::BODY_NONE;
		cmd.body_byte = c;
		prog_nx = 3'd0;
		col_nx = col_q;
		cls_nx = cls_q;

		if (data_ch.end_of_message) begin
			if (in_prog) begin
				cmd.pfx_len = p;
				sum = {1'b0, col_q} + {5'd0, p};
				if (sum > {1'b0, limit_q}) begin
					cmd.brk1 = 1'b1;
					col1 = '0;
				end else begin
					col1 = sum[6:0];
				end
			end
			if (col1 != '0) begin
				cmd.body = qpe_pkg::BODY_CLOSE;
			end
			col_nx = '0;
			cls_nx = qpe_pkg::CLS_OTHER;
		end else if (in_prog && (c == qpe_pkg::from_char(p)) && (p != 3'd4)) begin
			prog_nx = p + 3'd1;
		end else begin
			if (in_prog) begin
				if (c == qpe_pkg::from_char(p)) begin
					cmd.pfx_len = 3'd6;
					cmd.pfx_esc = 1'b1;
					sum = {1'b0, col_q} + 8'd6;
				end else begin
					cmd.pfx_len = p;
					sum = {1'b0, col_q} + {5'd0, p};
				end
				if (sum > {1'b0, limit_q}) begin
					cmd.brk1 = 1'b1;
					col1 = '0;
					cls1 = qpe_pkg::CLS_NEWLINE;
				end else begin
					col1 = sum[6:0];
					cls1 = qpe_pkg::CLS_OTHER;
				end
			end
			do_enc = 1'b1;
		end

		if (do_enc) begin
			col_nx = col1;
			cls_nx = cls1;
			esc = ((c < qpe_pkg::CH_CTL_END) && (c != qpe_pkg::CH_LF) && (c != qpe_pkg::CH_TAB))
				|| (c == qpe_pkg::CH_EQ) || (c >= qpe_pkg::CH_DEL)
				|| ((col1 == '0) && (c == qpe_pkg::CH_DOT));
			if (esc || !((c == qpe_pkg::CH_LF)
					|| ((c == qpe_pkg::CH_F) && (cls1 == qpe_pkg::CLS_NEWLINE)))) begin
				if (esc) begin
					cmd.body = qpe_pkg::BODY_ESC;
					sum = {1'b0, col1} + 8'd3;
					cls_nx = qpe_pkg::CLS_OTHER;
				end else begin
					cmd.body = qpe_pkg::BODY_LIT;
					sum = {1'b0, col1} + 8'd1;
					cls_nx = ((c == qpe_pkg::CH_SP) || (c == qpe_pkg::CH_TAB)) ?
						qpe_pkg::CLS_BLANK : qpe_pkg::CLS_OTHER;
				end
				if (sum > {1'b0, limit_q}) begin
					cmd.brk2 = 1'b1;
					col_nx = '0;
					cls_nx = qpe_pkg::CLS_NEWLINE;
				end else begin
					col_nx = sum[6:0];
				end
			end else if (c == qpe_pkg::CH_LF) begin
				cmd.body = (cls1 == qpe_pkg::CLS_BLANK) ?
					qpe_pkg::BODY_BLANK_LF : qpe_pkg::BODY_LF;
				col_nx = '0;
				cls_nx = qpe_pkg::CLS_NEWLINE;
			end else begin
				prog_nx = 3'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= qpe_pkg::LIMIT_RESET;
			col_q <= '0;
			cls_q <= qpe_pkg::CLS_OTHER;
			prog_q <= 3'd0;
		end else begin
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			if (accept) begin
				col_q <= col_nx;
				cls_q <= cls_nx;
				prog_q <= prog_nx;
			end
		end
	end

endmodule

### design/qpe_fifo.sv
// ----------------------------------------------------------------------------
// Quoted-printable encoder command queue
// Small first-in first-out store of commands between front and back end.
// ----------------------------------------------------------------------------
module qpe_fifo #(
	parameter int unsigned DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  qpe_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output qpe_pkg::cmd_t head_cmd
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	qpe_pkg::cmd_t mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign head_cmd = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### design/qpe_back.sv
// ----------------------------------------------------------------------------
// Quoted-printable encoder back end
// Expands each queued command into its characters, one per cycle while the
// output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module qpe_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  qpe_pkg::cmd_t q_head,
	output logic          q_pop,
	qpe_out_if.source     text_ch
);

	logic [3:0] idx_q;
	logic       ov_q;
	logic [7:0] ob_q;
	logic       ol_q;

	logic [3:0] b_end;
	logic [3:0] c_end;
	logic [3:0] total;
	logic [3:0] rel;
	logic [7:0] ch;
	logic       is_last;
	logic       load;

	assign b_end = {1'b0, q_head.pfx_len} + (q_head.brk1 ? 4'd3 : 4'd0);
	assign c_end = b_end + {2'b00, qpe_pkg::body_len(q_head.body)};
	assign total = c_end + (q_head.brk2 ? 4'd3 : 4'd0);
	assign is_last = (idx_q == total - 4'd1);
	assign load = !q_empty && (!ov_q || text_ch.ready);
	assign q_pop = load && is_last;

	always_comb begin
		rel = 4'd0;
		if (idx_q < {1'b0, q_head.pfx_len}) begin
			ch = q_head.pfx_esc ? qpe_pkg::esc_from_char(idx_q[2:0])
				: qpe_pkg::from_char(idx_q[2:0]);
		end else if (idx_q < b_end) begin
			rel = idx_q - {1'b0, q_head.pfx_len};
			ch = qpe_pkg::break_char(rel[1:0]);
		end else if (idx_q < c_end) begin
			rel = idx_q - b_end;
			ch = qpe_pkg::body_char(q_head.body, q_head.body_byte, rel[1:0]);
		end else begin
			rel = idx_q - c_end;
			ch = qpe_pkg::break_char(rel[1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 4'd0;
			ov_q <= 1'b0;
		end else begin
			if (load) begin
				ov_q <= 1'b1;
				idx_q <= is_last ? 4'd0 : idx_q + 4'd1;
			end else if (text_ch.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ob_q <= ch;
			ol_q <= is_last;
		end
	end

	assign text_ch.valid = ov_q;
	assign text_ch.out_byte = ob_q;
	assign text_ch.last = ol_q;

endmodule

### design/quoted_printable_encoder.sv
// ----------------------------------------------------------------------------
// Quoted-printable encoder
// Turns a raw byte stream into quoted-printable text, one character per
// output request, with soft line breaks past a programmable column limit.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload                        Per request
//  data_ch   in         data_byte[7:0], end_of_message one byte or end mark
//  text_ch   out        out_byte[7:0], last            one text character
//  cfg_wr_*  in         cfg_wr_data[6:0]               line_limit write
//
// The front end takes one input request per cycle while the command queue
// has room. The back end spends one cycle per output character while the
// output is not stalled; this output loop sets the throughput. Bytes that
// produce no text push no command to the back end.
// Reset clears line state and the queue and sets line_limit to 72.
// Each side stalls independently through the queue and the output register.
// ----------------------------------------------------------------------------
module quoted_printable_encoder #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	qpe_in_if.sink     data_ch,
	qpe_out_if.source  text_ch,
	input  logic       cfg_wr_en,
	input  logic [6:0] cfg_wr_data
);

	logic          q_push;
	logic          q_full;
	logic          q_pop;
	logic          q_empty;
	qpe_pkg::cmd_t q_in;
	qpe_pkg::cmd_t q_head;

	qpe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_ch    (data_ch),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_cmd      (q_in)
	);

	qpe_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_cmd(q_in),
		.full    (q_full),
		.pop     (q_pop),
		.empty   (q_empty),
		.head_cmd(q_head)
	);

	qpe_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_empty(q_empty),
		.q_head (q_head),
		.q_pop  (q_pop),
		.text_ch(text_ch)
	);

endmodule

### tb/sv/quoted_printable_encoder_checker.sv
// ----------------------------------------------------------------------------
// Quoted-printable encoder checker
// Watches the input, output and line_limit ports, works out the encoded text
// that each accepted request must produce and compares every output
// character and its last flag, in order, against that text.
// ----------------------------------------------------------------------------
module quoted_printable_encoder_checker (
	input  logic       clk,
	input  logic       arst_n,
	qpe_in_if          data_ch,
	qpe_out_if         text_ch,
	input  logic       cfg_wr_en,
	input  logic [6:0] cfg_wr_data,
	output int         fail_count,
	output int         text_pending,
	output int         checked_count
);

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} text_char_t;

	localparam logic [39:0] FROM_TEXT     = "From ";
	localparam logic [47:0] ESC_FROM_TEXT = "=46rom";

	qpe_pkg::col_t line_limit;
	qpe_pkg::col_t column;
	qpe_pkg::cls_t prev_class;
	logic [2:0]    from_held;

	logic [7:0] step_text[$];
	text_char_t expected_text[$];
	text_char_t want;

	function automatic logic [7:0] from_byte(input int i);
		return FROM_TEXT[8*(4-i) +: 8];
	endfunction

	function automatic logic [7:0] nibble_ascii(input logic [3:0] n);
		return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h41 + 8'(n) - 8'd10;
	endfunction

	function automatic void put_char(input logic [7:0] ch);
		step_text.push_back(ch);
	endfunction

	function automatic void put_soft_break();
		put_char(qpe_pkg::CH_EQ);
		put_char(qpe_pkg::CH_CR);
		put_char(qpe_pkg::CH_LF);
	endfunction

	function automatic void count_columns(input int k);
		int n;
		n = int'(column) + k;
		if (n > int'(line_limit)) begin
			put_soft_break();
			column = '0;
			prev_class = qpe_pkg::CLS_NEWLINE;
		end else begin
			column = qpe_pkg::col_t'(n);
		end
	endfunction

	function automatic void flush_held();
		int p;
		p = int'(from_held);
		from_held = '0;
		if (p >= 1 && p <= 4) begin
			for (int i = 0; i < p; i++)
				put_char(from_byte(i));
			prev_class = qpe_pkg::CLS_OTHER;
			count_columns(p);
		end
	endfunction

	function automatic void encode_char(input logic [7:0] c);
		logic esc;
		esc = (c < qpe_pkg::CH_CTL_END && c != qpe_pkg::CH_LF && c != qpe_pkg::CH_TAB) ||
			c == qpe_pkg::CH_EQ || c >= qpe_pkg::CH_DEL ||
			(column == '0 && c == qpe_pkg::CH_DOT);
		if (esc) begin
			put_char(qpe_pkg::CH_EQ);
			put_char(nibble_ascii(c[7:4]));
			put_char(nibble_ascii(c[3:0]));
			prev_class = qpe_pkg::CLS_OTHER;
			count_columns(3);
		end else if (c == qpe_pkg::CH_LF) begin
			if (prev_class == qpe_pkg::CLS_BLANK) begin
				put_char(qpe_pkg::CH_EQ);
				put_char(qpe_pkg::CH_LF);
			end
			put_char(qpe_pkg::CH_LF);
			column = '0;
			prev_class = qpe_pkg::CLS_NEWLINE;
		end else if (c == qpe_pkg::CH_F && prev_class == qpe_pkg::CLS_NEWLINE) begin
			from_held = 3'd1;
		end else begin
			put_char(c);
			prev_class = (c == qpe_pkg::CH_SP || c == qpe_pkg::CH_TAB) ?
				qpe_pkg::CLS_BLANK : qpe_pkg::CLS_OTHER;
			count_columns(1);
		end
	endfunction

	function automatic void predict_text(input logic [7:0] b, input logic eom);
		int p;
		step_text.delete();
		p = int'(from_held);
		if (eom) begin
			flush_held();
			if (column != '0)
				put_soft_break();
			column = '0;
			prev_class = qpe_pkg::CLS_OTHER;
			from_held = '0;
		end else if (p >= 1 && p <= 4) begin
			if (b == from_byte(p)) begin
				if (p < 4) begin
					from_held = 3'(p + 1);
				end else begin
					for (int i = 0; i < 6; i++)
						put_char(ESC_FROM_TEXT[8*(5-i) +: 8]);
					from_held = '0;
					prev_class = qpe_pkg::CLS_OTHER;
					count_columns(6);
					encode_char(b);
				end
			end else begin
				flush_held();
				encode_char(b);
			end
		end else begin
			from_held = '0;
			encode_char(b);
		end
		foreach (step_text[i])
			expected_text.push_back(text_char_t'{step_text[i], i == step_text.size() - 1});
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_text.delete();
			line_limit = qpe_pkg::LIMIT_RESET;
			column = '0;
			prev_class = qpe_pkg::CLS_OTHER;
			from_held = '0;
			fail_count = 0;
			checked_count = 0;
			text_pending <= 0;
		end else begin
			if (text_ch.valid && text_ch.ready) begin
				checked_count++;
				if (expected_text.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected character, expected none, got %h last %b",
						$realtime, text_ch.out_byte, text_ch.last);
				end else begin
					want = expected_text.pop_front();
					if (text_ch.out_byte !== want.out_byte || text_ch.last !== want.last) begin
						fail_count++;
						$display("%0t: text mismatch, expected %h last %b, got %h last %b",
							$realtime, want.out_byte, want.last, text_ch.out_byte,
							text_ch.last);
					end
				end
			end
			if (cfg_wr_en)
				line_limit = cfg_wr_data;
			if (data_ch.valid && data_ch.ready)
				predict_text(data_ch.data_byte, data_ch.end_of_message);
			text_pending <= expected_text.size();
		end
	end

endmodule

### tb/sv/quoted_printable_encoder_tb.sv
// ----------------------------------------------------------------------------
// Quoted-printable encoder testbench
// Drives a directed set of bytes and then random message text with "From "
// prefixes, end marks and escapes through several line limits, while both
// channel sides stall at random, and gives the verdict from the checker.
// ----------------------------------------------------------------------------
module quoted_printable_encoder_tb;

	localparam logic [39:0] FROM_TEXT = "From ";
	localparam int DIRECTED_COUNT = 26;
	localparam logic [8:0] DIRECTED [DIRECTED_COUNT] = '{
		{1'b0, qpe_pkg::CH_DOT}, {1'b0, 8'h00}, {1'b0, 8'hFF},
		{1'b0, qpe_pkg::CH_DEL}, {1'b0, 8'h7E}, {1'b0, qpe_pkg::CH_EQ},
		{1'b0, qpe_pkg::CH_TAB}, {1'b0, qpe_pkg::CH_SP}, {1'b0, qpe_pkg::CH_LF},
		{1'b0, "F"}, {1'b0, "r"}, {1'b0, "o"}, {1'b0, "m"}, {1'b0, qpe_pkg::CH_SP},
		{1'b0, qpe_pkg::CH_LF}, {1'b0, "F"}, {1'b0, "r"}, {1'b0, "x"},
		{1'b0, qpe_pkg::CH_LF},
		{1'b0, "F"}, {1'b0, "r"}, {1'b0, "o"}, {1'b1, 8'hA5}, {1'b1, 8'h5A},
		{1'b0, "F"}, {1'b1, 8'h00}
	};

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [6:0]  cfg_wr_data;
	int          fail_count;
	int          text_pending;
	int          checked_count;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned hold_token;
	int          sent_count;
	bit          line_start;

	qpe_in_if  data_ch();
	qpe_out_if text_ch();

	quoted_printable_encoder DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_ch     (data_ch),
		.text_ch     (text_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	quoted_printable_encoder_checker text_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.data_ch       (data_ch),
		.text_ch       (text_ch),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.fail_count    (fail_count),
		.text_pending  (text_pending),
		.checked_count (checked_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

	// A change of hold_token makes the receiver hold off for a long stretch.
	initial begin
		int unsigned hold_seen;
		hold_seen = 0;
		text_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_token != hold_seen) begin
				hold_seen = hold_token;
				text_ch.ready <= 1'b0;
				repeat (80) @(posedge clk);
			end
			text_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_request(input logic [7:0] b, input logic eom);
		if ($urandom_range(99) < send_idle_pct) begin
			data_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		data_ch.valid <= 1'b1;
		data_ch.data_byte <= b;
		data_ch.end_of_message <= eom;
		do @(posedge clk); while (!data_ch.ready);
		sent_count++;
		line_start = !eom && b == qpe_pkg::CH_LF;
	endtask

	function automatic logic [7:0] random_text_byte();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 8) return qpe_pkg::CH_LF;
		if (r < 14) return qpe_pkg::CH_SP;
		if (r < 17) return qpe_pkg::CH_TAB;
		if (r < 21) return qpe_pkg::CH_DOT;
		if (r < 24) return qpe_pkg::CH_EQ;
		if (r < 32) return 8'($urandom_range(255, 128));
		if (r < 36) return 8'($urandom_range(31, 0));
		if (r < 38) return qpe_pkg::CH_DEL;
		if (r < 41) return qpe_pkg::CH_F;
		return 8'($urandom_range(126, 33));
	endfunction

	task automatic send_random_text(input int count);
		int n;
		int plen;
		n = 0;
		while (n < count) begin
			if ($urandom_range(99) < (line_start ? 40 : 4)) begin
				plen = $urandom_range(5, 1);
				for (int i = 0; i < plen; i++)
					send_request(FROM_TEXT[8*(4-i) +: 8], 1'b0);
				n += plen;
			end else if ($urandom_range(99) < 3) begin
				send_request(8'($urandom), 1'b1);
				n++;
			end else begin
				send_request(random_text_byte(), 1'b0);
				n++;
			end
		end
		send_request(8'($urandom), 1'b1);
	endtask

	task automatic drain_text();
		data_ch.valid <= 1'b0;
		do @(posedge clk); while (text_pending != 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_limit(input logic [6:0] value);
		drain_text();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		int rand_limit;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		data_ch.valid <= 1'b0;
		data_ch.data_byte <= '0;
		data_ch.end_of_message <= 1'b0;
		send_idle_pct <= 34;
		recv_idle_pct <= 84;
		hold_token <= 0;
		sent_count = 0;
		line_start = 1'b0;
		rand_limit = $urandom_range(120, 8);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i])
			send_request(DIRECTED[i][7:0], DIRECTED[i][8]);
		send_random_text(60);

		set_limit(7'd8);
		send_idle_pct <= 84;
		recv_idle_pct <= 34;
		send_random_text(60);

		set_limit(7'd120);
		send_idle_pct <= 0;
		recv_idle_pct <= 0;
		hold_token <= hold_token + 1;
		send_random_text(50);

		set_limit(7'd0);
		send_random_text(15);

		set_limit(7'(rand_limit));
		send_random_text(15);

		drain_text();
		$display("Summary: %0d input requests sent, %0d encoded characters checked,",
			sent_count, checked_count);
		$display("with line limits 72, 8, 120, 0 and %0d, random stalls and a long output hold.",
			rand_limit);
		if (fail_count == 0 && text_pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
